[design/uvs_pkg.sv]
`default_nettype none
package uvs_pkg;

  localparam int unsigned SegW          = 9;
  localparam int unsigned AngW          = 32;
  localparam int unsigned DivLanes      = 4;
  localparam int unsigned DivStages     = 8;
  localparam int unsigned DivSteps      = AngW / DivStages;
  localparam int unsigned CordicStages  = 16;
  localparam int unsigned AtanEntries   = 24;

  localparam logic [SegW-1:0] MaxSegments = 9'd256;

  localparam logic signed [31:0] GainQ30 = 32'sd652032874;
  localparam logic signed [31:0] OneQ30  = 32'sd1073741824;

  localparam logic [31:0] AtanTurn [AtanEntries] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Configuration register indexes.
  localparam logic [1:0] CfgRadius   = 2'd0;
  localparam logic [1:0] CfgSegments = 2'd1;

  // One lane of the long division: running remainder, dividend bits still
  // to shift in, and quotient bits produced so far.
  typedef struct packed {
    logic [SegW-1:0] rem;
    logic [AngW-1:0] low;
    logic [AngW-1:0] quo;
    logic            qhi;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [DivLanes-1:0] lane;
    logic [SegW-1:0]          seg;
    logic                     ok;
  } div_item_t;

  typedef struct packed {
    logic [16:0] u;
    logic [16:0] v;
    logic        ok;
  } side_t;

  typedef struct packed {
    logic signed [31:0] ct;
    logic signed [31:0] st;
    logic signed [31:0] cp;
    logic signed [31:0] sp;
  } trig_t;

  // Signed right shift that rounds half away from zero.
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic [63:0] half;
    logic [63:0] mag;
    half = 64'd1 << (s - 1);
    if (v >= 0) begin
      mag = (64'(v) + half) >> s;
      return $signed(mag);
    end
    mag = (64'(-v) + half) >> s;
    return -$signed(mag);
  endfunction

  function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                             input logic signed [63:0] lo,
                                             input logic signed [63:0] hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

[design/uvs_divider.sv]
`default_nettype none
module uvs_divider import uvs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire div_item_t in_item_i,
  output logic           out_valid_o,
  output div_item_t      out_item_o
);

  // Restoring division, a few quotient bits per stage on every lane.
  function automatic div_lane_t div_step(input div_lane_t l, input logic [SegW-1:0] seg);
    logic [SegW:0] r2;
    div_lane_t     n;
    r2 = {l.rem, l.low[AngW-1]};
    n  = l;
    if (r2 >= {1'b0, seg}) begin
      n.rem = SegW'(r2 - {1'b0, seg});
      n.quo = {l.quo[AngW-2:0], 1'b1};
    end else begin
      n.rem = r2[SegW-1:0];
      n.quo = {l.quo[AngW-2:0], 1'b0};
    end
    n.low = {l.low[AngW-2:0], 1'b0};
    return n;
  endfunction

  div_item_t            stage_q [DivStages];
  div_item_t            stage_d [DivStages];
  logic [DivStages-1:0] vld_q;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    always_comb begin
      div_item_t it;
      it = (s == 0) ? in_item_i : stage_q[(s == 0) ? 0 : s - 1];
      for (int k = 0; k < DivSteps; k++) begin
        for (int l = 0; l < DivLanes; l++) begin
          it.lane[l] = div_step(it.lane[l], it.seg);
        end
      end
      stage_d[s] = it;
    end

    always_ff @(posedge clk_i) begin
      stage_q[s] <= stage_d[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= (s == 0) ? in_valid_i : vld_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign out_valid_o = vld_q[DivStages-1];
  assign out_item_o  = stage_q[DivStages-1];

endmodule
`default_nettype wire

[design/uvs_cordic.sv]
`default_nettype none
module uvs_cordic import uvs_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [AngW-1:0] theta_i,
  input  wire logic [AngW-1:0] phi_i,
  input  wire side_t           side_i,
  output logic                 out_valid_o,
  output trig_t                trig_o,
  output side_t                side_o
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         quad;
    logic               zero;
  } cord_t;

  function automatic cord_t cord_init(input logic [AngW-1:0] ang);
    cord_t c;
    c.quad = ang[AngW-1:AngW-2];
    c.z    = $signed({2'b00, ang[AngW-3:0]});
    c.zero = (ang[AngW-3:0] == '0);
    c.x    = GainQ30;
    c.y    = '0;
    return c;
  endfunction

  function automatic cord_t cord_iter(input cord_t c, input int unsigned i);
    cord_t n;
    n = c;
    if (c.z >= 0) begin
      n.x = c.x - (c.y >>> i);
      n.y = c.y + (c.x >>> i);
      n.z = c.z - $signed(AtanTurn[i]);
    end else begin
      n.x = c.x + (c.y >>> i);
      n.y = c.y - (c.x >>> i);
      n.z = c.z + $signed(AtanTurn[i]);
    end
    return n;
  endfunction

  // Exact axis angles bypass the iterations, then the quadrant rotation.
  function automatic logic signed [63:0] cord_cs(input cord_t c);
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] co;
    logic signed [31:0] si;
    x = c.zero ? OneQ30 : c.x;
    y = c.zero ? '0 : c.y;
    case (c.quad)
      2'd0:    begin co = x;  si = y;  end
      2'd1:    begin co = -y; si = x;  end
      2'd2:    begin co = -x; si = -y; end
      default: begin co = y;  si = -x; end
    endcase
    return {co, si};
  endfunction

  cord_t                   th_q [CordicStages];
  cord_t                   ph_q [CordicStages];
  side_t                   sd_q [CordicStages];
  logic [CordicStages-1:0] vld_q;

  for (genvar s = 0; s < CordicStages; s++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (s == 0) begin
        th_q[s] <= cord_iter(cord_init(theta_i), s);
        ph_q[s] <= cord_iter(cord_init(phi_i), s);
        sd_q[s] <= side_i;
      end else begin
        th_q[s] <= cord_iter(th_q[(s == 0) ? 0 : s - 1], s);
        ph_q[s] <= cord_iter(ph_q[(s == 0) ? 0 : s - 1], s);
        sd_q[s] <= sd_q[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= (s == 0) ? in_valid_i : vld_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  trig_t trig_q;
  side_t side_q;
  logic  out_vld_q;
  logic signed [63:0] th_cs;
  logic signed [63:0] ph_cs;

  assign th_cs = cord_cs(th_q[CordicStages-1]);
  assign ph_cs = cord_cs(ph_q[CordicStages-1]);

  always_ff @(posedge clk_i) begin
    trig_q.ct <= th_cs[63:32];
    trig_q.st <= th_cs[31:0];
    trig_q.cp <= ph_cs[63:32];
    trig_q.sp <= ph_cs[31:0];
    side_q    <= sd_q[CordicStages-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[CordicStages-1];
    end
  end

  assign out_valid_o = out_vld_q;
  assign trig_o      = trig_q;
  assign side_o      = side_q;

endmodule
`default_nettype wire

[design/uvs_post.sv]
`default_nettype none
module uvs_post import uvs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire trig_t       trig_i,
  input  wire side_t       side_i,
  input  wire logic [15:0] radius_i,
  output logic             valid_o,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic signed [15:0] tan_x_o,
  output logic signed [15:0] tan_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic               in_range_o
);

  localparam logic signed [63:0] PosHi  = 64'sd65535;
  localparam logic signed [63:0] PosLo  = -64'sd65535;
  localparam logic signed [63:0] UnitHi = 64'sd32767;
  localparam logic signed [63:0] UnitLo = -64'sd32768;

  logic [3:0] vld_q;

  // Stage 1: sin(phi) times cos and sin of theta.
  logic signed [63:0] s1_mp_q, s1_mq_q;
  logic signed [31:0] s1_cp_q, s1_ct_q, s1_st_q;
  side_t              s1_sd_q;
  // Stage 2: rounded products, normal y and tangent.
  logic signed [31:0] s2_p_q, s2_q_q, s2_cp_q;
  logic signed [15:0] s2_ny_q, s2_tx_q, s2_tz_q;
  side_t              s2_sd_q;
  // Stage 3: radius products, normal x and z.
  logic signed [63:0] s3_rp_q, s3_ry_q, s3_rq_q;
  logic signed [15:0] s3_nx_q, s3_ny_q, s3_nz_q, s3_tx_q, s3_tz_q;
  side_t              s3_sd_q;
  // Stage 4: output register.
  logic signed [16:0] s4_px_q, s4_py_q, s4_pz_q;
  logic signed [15:0] s4_nx_q, s4_ny_q, s4_nz_q, s4_tx_q, s4_tz_q;
  side_t              s4_sd_q;

  logic signed [63:0] mp_d, mq_d, rp_d, ry_d, rq_d;
  logic signed [16:0] rad_s;
  logic signed [63:0] tmp_p, tmp_q, tmp_ny, tmp_tx, tmp_tz, tmp_nx, tmp_nz;
  logic signed [63:0] tmp_px, tmp_py, tmp_pz;

  assign rad_s = $signed({1'b0, radius_i});
  assign mp_d  = 64'(trig_i.sp) * 64'(trig_i.ct);
  assign mq_d  = 64'(trig_i.sp) * 64'(trig_i.st);
  assign rp_d  = 64'(rad_s) * 64'(s2_p_q);
  assign ry_d  = 64'(rad_s) * 64'(s2_cp_q);
  assign rq_d  = 64'(rad_s) * 64'(s2_q_q);

  assign tmp_p  = shr_round(s1_mp_q, 30);
  assign tmp_q  = shr_round(s1_mq_q, 30);
  assign tmp_ny = sat(shr_round(64'(s1_cp_q), 15), UnitLo, UnitHi);
  assign tmp_tx = sat(shr_round(-64'(s1_st_q), 15), UnitLo, UnitHi);
  assign tmp_tz = sat(shr_round(64'(s1_ct_q), 15), UnitLo, UnitHi);
  assign tmp_nx = sat(shr_round(64'(s2_p_q), 15), UnitLo, UnitHi);
  assign tmp_nz = sat(shr_round(64'(s2_q_q), 15), UnitLo, UnitHi);
  assign tmp_px = sat(shr_round(s3_rp_q, 30), PosLo, PosHi);
  assign tmp_py = sat(shr_round(s3_ry_q, 30), PosLo, PosHi);
  assign tmp_pz = sat(shr_round(s3_rq_q, 30), PosLo, PosHi);

  always_ff @(posedge clk_i) begin
    s1_mp_q <= mp_d;
    s1_mq_q <= mq_d;
    s1_cp_q <= trig_i.cp;
    s1_ct_q <= trig_i.ct;
    s1_st_q <= trig_i.st;
    s1_sd_q <= side_i;

    s2_p_q  <= tmp_p[31:0];
    s2_q_q  <= tmp_q[31:0];
    s2_cp_q <= s1_cp_q;
    s2_ny_q <= tmp_ny[15:0];
    s2_tx_q <= tmp_tx[15:0];
    s2_tz_q <= tmp_tz[15:0];
    s2_sd_q <= s1_sd_q;

    s3_rp_q <= rp_d;
    s3_ry_q <= ry_d;
    s3_rq_q <= rq_d;
    s3_nx_q <= tmp_nx[15:0];
    s3_nz_q <= tmp_nz[15:0];
    s3_ny_q <= s2_ny_q;
    s3_tx_q <= s2_tx_q;
    s3_tz_q <= s2_tz_q;
    s3_sd_q <= s2_sd_q;

    s4_px_q <= tmp_px[16:0];
    s4_py_q <= tmp_py[16:0];
    s4_pz_q <= tmp_pz[16:0];
    s4_nx_q <= s3_nx_q;
    s4_ny_q <= s3_ny_q;
    s4_nz_q <= s3_nz_q;
    s4_tx_q <= s3_tx_q;
    s4_tz_q <= s3_tz_q;
    s4_sd_q <= s3_sd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  assign valid_o    = vld_q[3];
  assign pos_x_o    = s4_px_q;
  assign pos_y_o    = s4_py_q;
  assign pos_z_o    = s4_pz_q;
  assign norm_x_o   = s4_nx_q;
  assign norm_y_o   = s4_ny_q;
  assign norm_z_o   = s4_nz_q;
  assign tan_x_o    = s4_tx_q;
  assign tan_z_o    = s4_tz_q;
  assign tex_u_o    = s4_sd_q.u;
  assign tex_v_o    = s4_sd_q.v;
  assign in_range_o = s4_sd_q.ok;

endmodule
`default_nettype wire

[design/uv_sphere_vertex_generator_core.sv]
`default_nettype none
// Channel   Handshake                  Payload
// input     start_i, busy_o            grid_column_i, grid_row_i
// config    cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
// result    valid_o (one-cycle strobe) pos_*, norm_*, tan_*, tex_*, in_range_o
//
// One item is taken in every cycle; busy_o stays low and cfg_ready_o high.
// Each result passes through the entry register,
// eight long-division stages (four quotient bits each), sixteen CORDIC
// iteration stages plus a quadrant stage, and four multiply and round stages.
// Reset clears the valid bits and loads radius 1.0 and sixteen segments.
// The receiver must take every strobe, which the block does not check; nothing in the pipeline ever stalls.
module uv_sphere_vertex_generator_core import uvs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [8:0]  grid_column_i,
  input  wire logic [8:0]  grid_row_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             valid_o,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic signed [15:0] tan_x_o,
  output logic signed [15:0] tan_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic               in_range_o
);

  logic [15:0]     radius_q;
  logic [SegW-1:0] seg_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      seg_q    <= 9'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRadius:   radius_q <= cfg_data_i;
        CfgSegments: seg_q    <= cfg_data_i[SegW-1:0];
        default: ;
      endcase
    end
  end

  // Effective segment count and index clamping.
  logic [SegW-1:0] seg_eff, col_c, row_c;
  logic [7:0]      half;
  logic            ok_c;

  always_comb begin
    if (seg_q == '0) begin
      seg_eff = 9'd1;
    end else if (seg_q > MaxSegments) begin
      seg_eff = MaxSegments;
    end else begin
      seg_eff = seg_q;
    end
    half  = seg_eff[8:1];
    ok_c  = (grid_column_i <= seg_eff) && (grid_row_i <= seg_eff);
    col_c = (grid_column_i > seg_eff) ? seg_eff : grid_column_i;
    row_c = (grid_row_i > seg_eff) ? seg_eff : grid_row_i;
  end

  // Since the index never exceeds the count, the first quotient bit is just
  // "index equals count" and the remainder starts below the count. The half
  // count rounding term sits at a different place in lanes 0, 2 and 1/3 (the
  // texture lanes share one) so that all lanes run the same 32 division steps.
  function automatic div_lane_t lane_init(input logic [SegW-1:0] idx,
                                          input logic [SegW-1:0] seg,
                                          input logic [AngW-1:0] low);
    div_lane_t l;
    l.qhi = (idx == seg);
    l.rem = l.qhi ? '0 : idx;
    l.low = low;
    l.quo = '0;
    return l;
  endfunction

  div_item_t entry_d, entry_q;
  logic      entry_vld_q;

  always_comb begin
    entry_d.lane[0] = lane_init(col_c, seg_eff, {24'd0, half});
    entry_d.lane[1] = lane_init(col_c, seg_eff, {8'd0, half, 16'd0});
    entry_d.lane[2] = lane_init(row_c, seg_eff, {23'd0, half, 1'b0});
    entry_d.lane[3] = lane_init(row_c, seg_eff, {8'd0, half, 16'd0});
    entry_d.seg     = seg_eff;
    entry_d.ok      = ok_c;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= 1'b0;
    end else begin
      entry_vld_q <= start_i && !busy_o;
    end
  end

  logic      div_vld;
  div_item_t div_item;

  uvs_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (entry_vld_q),
    .in_item_i   (entry_q),
    .out_valid_o (div_vld),
    .out_item_o  (div_item)
  );

  // Theta is the full quotient modulo a turn; the others drop the extra
  // fraction bits that the shifted rounding term produced.
  logic [AngW-1:0] theta, phi;
  side_t           side_d;

  assign theta     = div_item.lane[0].quo;
  assign phi       = {div_item.lane[2].qhi, div_item.lane[2].quo[AngW-1:1]};
  assign side_d.u  = {div_item.lane[1].qhi, div_item.lane[1].quo[AngW-1:16]};
  assign side_d.v  = {div_item.lane[3].qhi, div_item.lane[3].quo[AngW-1:16]};
  assign side_d.ok = div_item.ok;

  logic  cor_vld;
  trig_t cor_trig;
  side_t cor_side;

  uvs_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_vld),
    .theta_i     (theta),
    .phi_i       (phi),
    .side_i      (side_d),
    .out_valid_o (cor_vld),
    .trig_o      (cor_trig),
    .side_o      (cor_side)
  );

  uvs_post u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cor_vld),
    .trig_i     (cor_trig),
    .side_i     (cor_side),
    .radius_i   (radius_q),
    .valid_o    (valid_o),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .norm_x_o   (norm_x_o),
    .norm_y_o   (norm_y_o),
    .norm_z_o   (norm_z_o),
    .tan_x_o    (tan_x_o),
    .tan_z_o    (tan_z_o),
    .tex_u_o    (tex_u_o),
    .tex_v_o    (tex_v_o),
    .in_range_o (in_range_o)
  );

endmodule
`default_nettype wire

[design/uvs_checker.sv]
`default_nettype none
module uvs_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               valid_o,
  input wire logic signed [15:0] norm_y_o,
  input wire logic signed [15:0] tan_x_o,
  input wire logic signed [15:0] tan_z_o,
  input wire logic [16:0]        tex_u_o,
  input wire logic [16:0]        tex_v_o
);

  // The valid bits may be unknown until the first edge that sees reset, so the
  // strobe is checked from the cycle after reset is seen low.
  a_no_valid_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !valid_o)
    else $error("result strobe during reset");

  a_tex_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (tex_u_o <= 17'd65536) && (tex_v_o <= 17'd65536))
    else $error("texture coordinate beyond one");

  // The top row is the north pole: the normal points straight up.
  a_pole_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (tex_v_o == 17'd0) |-> (norm_y_o == 16'sd32767))
    else $error("pole normal is not straight up");

  // The first column has azimuth zero, so the tangent is the z axis.
  a_seam_tangent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (tex_u_o == 17'd0) |-> (tan_x_o == 16'sd0) && (tan_z_o == 16'sd32767))
    else $error("seam tangent is not the z axis");

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_uvs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_o  (valid_o),
  .norm_y_o (norm_y_o),
  .tan_x_o  (tan_x_o),
  .tan_z_o  (tan_z_o),
  .tex_u_o  (tex_u_o),
  .tex_v_o  (tex_v_o)
);
`default_nettype wire
